// ----- rtl/mpr_pkg.sv -----
// Package for the multi-page reassembler: item structs, kind and status codes.
// Used by every module of the block; depends on nothing.
package mpr_pkg;

  localparam int unsigned LEN_W   = 13;   // payload length and limit width
  localparam int unsigned MIN_PAYLOAD = 256;
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(4096);

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_INCOMPLETE = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_ORDER      = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_READ       = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  transmission_number;
    logic [7:0]  page_index;
    logic [7:0]  last_page_index;
    logic [7:0]  record_length;
    logic [7:0]  data_byte;
    logic [11:0] read_index;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] error_detail;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       read_data;
    logic [31:0]      pages_discarded;
    logic [31:0]      restart_count;
    logic [31:0]      overflow_count;
    logic [31:0]      completed_count;
  } out_t;

  // Flags that travel with a computed result from the engine to the output stage
  typedef struct packed {
    logic has_result;
    logic read_hit;
  } res_flags_t;

endpackage

// ----- rtl/multi_page_reassembler.sv -----
// Multi-page reassembler top level: input register, engine, result register.
// Depends on mpr_pkg, mpr_in_stage and mpr_engine.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    in_item (in_t)
//   out       source     out_valid/out_ready  out_item (out_t)
//   cfg       sink       cfg_wr_en            cfg_wr_data (max_payload)
//
// One item per cycle while out_ready keeps the result register free: an accepted
// item sits in the input register; when it advances, the engine updates state,
// store and counters and loads the result register, which holds a header or read result.
// Throughput is one item per cycle while the output does not stall; the payload
// store has one write port and one registered read port.
// A stalled result holds in the result register while the input register takes
// one more item. Synchronous reset clears control state and counters; the payload
// store is not cleared and needs no clearing pass.
module multi_page_reassembler
  import mpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 4096,
  parameter int unsigned MAX_RECORD    = 252
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_item,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned DEPTH_CAP = (PAYLOAD_DEPTH > LEN_MAX) ? LEN_MAX : PAYLOAD_DEPTH;

  logic       held;
  logic       advance;
  in_t        item;
  out_t       res;
  res_flags_t flags;
  logic [7:0] rd_q;
  out_t       res_q;
  logic       read_hit_q;
  out_t       out_comb;

  // Advance when the result slot is free or being emptied
  assign advance = held && (!out_valid || out_ready);

  mpr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .held     (held),
    .item     (item)
  );

  mpr_engine #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .MAX_RECORD    (MAX_RECORD)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (item),
    .res         (res),
    .flags       (flags),
    .rd_q        (rd_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && flags.has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && flags.has_result) begin
      res_q      <= res;
      read_hit_q <= flags.read_hit;
    end
  end

  // Read data arrives from the store register alongside the result
  always_comb begin
    out_comb           = res_q;
    out_comb.read_data = read_hit_q ? rd_q : 8'd0;
  end
  assign out_item = out_comb;

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.payload_length <= LEN_W'(DEPTH_CAP))
    else $error("payload length above store depth");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status != ST_READ |-> out_item.read_data == 8'd0)
    else $error("read data on a header result");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_ORDER |->
      out_item.error_detail != '0 && out_item.payload_length == '0)
    else $error("bad out-of-order report");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

endmodule

// ----- rtl/mpr_in_stage.sv -----
// Input register of the reassembler: holds one accepted item until the engine takes it.
// Depends on mpr_pkg.
module mpr_in_stage
  import mpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_item,
  input  logic advance,
  output logic held,
  output in_t  item
);

  // Free slot, or the held item leaves in this cycle
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ----- rtl/mpr_engine.sv -----
// Reassembly engine: assembly state, statistics counters, payload store and result build.
// Depends on mpr_pkg.
module mpr_engine
  import mpr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = 4096,
  parameter int unsigned MAX_RECORD    = 252
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             advance,
  input  in_t              item,
  output out_t             res,
  output res_flags_t       flags,
  output logic [7:0]       rd_q
);

  localparam int unsigned ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned DEPTH_CAP = (PAYLOAD_DEPTH > LEN_MAX) ? LEN_MAX : PAYLOAD_DEPTH;

  logic [LEN_W-1:0] max_payload;
  logic             assembling, assembling_next;
  logic [7:0]       held_transmission, held_transmission_next;
  logic [7:0]       held_page, held_page_next;
  logic [7:0]       held_last_page, held_last_page_next;
  logic [8:0]       pages_held, pages_held_next;
  logic [LEN_W-1:0] held_length, held_length_next;
  logic [LEN_W-1:0] write_pointer, write_pointer_next;
  logic             accepting_bytes, accepting_bytes_next;
  logic [31:0]      pages_discarded, pages_discarded_next;
  logic [31:0]      restart_count, restart_count_next;
  logic [31:0]      overflow_count, overflow_count_next;
  logic [31:0]      completed_count, completed_count_next;

  logic [7:0]       payload_store [PAYLOAD_DEPTH];
  logic             store_we;
  logic [ADDR_W-1:0] waddr, raddr;

  logic [LEN_W-1:0] limit;
  logic [7:0]       rl_eff;
  logic [LEN_W-1:0] len_trunc;      // held length after a short page is cut
  logic             cont;
  logic [LEN_W:0]   len_sum;
  logic             over_limit;
  logic             drop_count;
  logic [LEN_W-1:0] wp_inc;

  assign waddr = ADDR_W'(write_pointer);
  assign raddr = ADDR_W'(item.read_index);
  assign wp_inc = write_pointer + LEN_W'(1);

  always_comb begin
    limit = max_payload;
    if (max_payload < LEN_W'(MIN_PAYLOAD)) limit = LEN_W'(MIN_PAYLOAD);
    if (limit > LEN_W'(DEPTH_CAP)) limit = LEN_W'(DEPTH_CAP);
  end

  always_comb begin
    rl_eff = item.record_length;
    if (32'(item.record_length) > MAX_RECORD) rl_eff = 8'(MAX_RECORD);
  end

  // Header decisions
  assign len_trunc = accepting_bytes ? write_pointer : held_length;
  assign cont = assembling && (item.transmission_number == held_transmission) &&
                (item.last_page_index == held_last_page) &&
                (item.page_index == held_page + 8'd1);
  assign len_sum  = (cont ? {1'b0, len_trunc} : '0) + (LEN_W+1)'(rl_eff);
  assign over_limit = len_sum > {1'b0, limit};
  // A partial assembly is abandoned either by a mismatch or by a too-long continuation
  assign drop_count = assembling && (!cont || over_limit);

  always_comb begin
    assembling_next        = assembling;
    held_transmission_next = held_transmission;
    held_page_next         = held_page;
    held_last_page_next    = held_last_page;
    pages_held_next        = pages_held;
    held_length_next       = held_length;
    write_pointer_next     = write_pointer;
    accepting_bytes_next   = accepting_bytes;
    pages_discarded_next   = pages_discarded;
    restart_count_next     = restart_count;
    overflow_count_next    = overflow_count;
    completed_count_next   = completed_count;
    store_we               = 1'b0;
    flags                  = '0;
    res                    = '0;

    case (item.kind)
      KIND_BYTE: begin
        if (accepting_bytes && write_pointer < held_length &&
            32'(write_pointer) < PAYLOAD_DEPTH) begin
          store_we           = 1'b1;
          write_pointer_next = wp_inc;
        end
        if (write_pointer_next >= held_length) accepting_bytes_next = 1'b0;
      end
      KIND_CLEAR: begin
        held_length_next     = '0;
        write_pointer_next   = '0;
        accepting_bytes_next = 1'b0;
        pages_held_next      = '0;
        assembling_next      = 1'b0;
      end
      KIND_READ: begin
        flags.has_result = 1'b1;
        flags.read_hit   = ({1'b0, item.read_index} < write_pointer) &&
                           (32'(item.read_index) < PAYLOAD_DEPTH);
        res.status       = ST_READ;
      end
      default: begin
        flags.has_result = 1'b1;
        if (drop_count) begin
          pages_discarded_next = pages_discarded + 32'(pages_held);
          restart_count_next   = restart_count + 32'd1;
        end
        if (!cont && item.page_index != 8'd0) begin
          held_length_next     = '0;
          write_pointer_next   = '0;
          accepting_bytes_next = 1'b0;
          pages_held_next      = '0;
          assembling_next      = 1'b0;
          res.status           = ST_ORDER;
          res.error_detail     = LEN_W'(item.page_index);
        end else if (over_limit) begin
          overflow_count_next  = overflow_count + 32'd1;
          held_length_next     = '0;
          write_pointer_next   = '0;
          accepting_bytes_next = 1'b0;
          pages_held_next      = '0;
          assembling_next      = 1'b0;
          res.status           = ST_TOO_LONG;
          res.error_detail     = cont ? len_trunc : '0;
        end else begin
          held_length_next       = len_sum[LEN_W-1:0];
          if (!cont) write_pointer_next = '0;
          accepting_bytes_next   = (cont ? write_pointer : '0) < len_sum[LEN_W-1:0];
          held_transmission_next = item.transmission_number;
          held_page_next         = item.page_index;
          held_last_page_next    = item.last_page_index;
          if (item.page_index >= item.last_page_index) begin
            assembling_next      = 1'b0;
            pages_held_next      = '0;
            completed_count_next = completed_count + 32'd1;
            res.status           = ST_COMPLETE;
          end else begin
            assembling_next      = 1'b1;
            pages_held_next      = (cont ? pages_held : 9'd0) + 9'd1;
            res.status           = ST_INCOMPLETE;
          end
        end
      end
    endcase

    res.payload_length  = held_length_next;
    res.pages_discarded = pages_discarded_next;
    res.restart_count   = restart_count_next;
    res.overflow_count  = overflow_count_next;
    res.completed_count = completed_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload       <= MAX_PAYLOAD_RESET;
      assembling        <= 1'b0;
      held_transmission <= '0;
      held_page         <= '0;
      held_last_page    <= '0;
      pages_held        <= '0;
      held_length       <= '0;
      write_pointer     <= '0;
      accepting_bytes   <= 1'b0;
      pages_discarded   <= '0;
      restart_count     <= '0;
      overflow_count    <= '0;
      completed_count   <= '0;
    end else begin
      if (cfg_wr_en) max_payload <= cfg_wr_data;
      if (advance) begin
        assembling        <= assembling_next;
        held_transmission <= held_transmission_next;
        held_page         <= held_page_next;
        held_last_page    <= held_last_page_next;
        pages_held        <= pages_held_next;
        held_length       <= held_length_next;
        write_pointer     <= write_pointer_next;
        accepting_bytes   <= accepting_bytes_next;
        pages_discarded   <= pages_discarded_next;
        restart_count     <= restart_count_next;
        overflow_count    <= overflow_count_next;
        completed_count   <= completed_count_next;
      end
    end
  end

  // Payload store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (advance && store_we) payload_store[waddr] <= item.data_byte;
    if (advance && item.kind == KIND_READ) rd_q <= payload_store[raddr];
  end

endmodule
